// ===== rtl/doarm_pkg.sv =====
// shared constants, codes and types for the dual output audio router mixer
package doarm_pkg;

   localparam int BLOCK_FRAMES = 144;

   localparam int IDX_W     = 10;
   localparam int SMP_W     = 16;
   localparam int ENTRY_W   = 2 * SMP_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUDIO_MODE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_MODE = 2'd2;

   localparam logic [2:0] MODE_PASS    = 3'd0;
   localparam logic [2:0] MODE_SWAP    = 3'd1;
   localparam logic [2:0] MODE_SCREEN  = 3'd2;
   localparam logic [2:0] MODE_COMBINE = 3'd3;
   localparam logic [2:0] MODE_SPLIT   = 3'd4;

   localparam logic [1:0] SCR_NONE      = 2'd0;
   localparam logic [1:0] SCR_SWAP      = 2'd1;
   localparam logic [1:0] SCR_MIRROR_TV = 2'd2;
   localparam logic [1:0] SCR_MIRROR_HH = 2'd3;

   typedef enum logic [2:0] {
      OP_PASS      = 3'd0,
      OP_SWAP      = 3'd1,
      OP_MIRROR_TV = 3'd2,
      OP_MIRROR_HH = 3'd3,
      OP_COMBINE   = 3'd4,
      OP_SPLIT     = 3'd5
   } op_type;

   typedef struct packed {
      logic              from_handheld;
      logic              emit;
      op_type            op;
      logic [IDX_W-1:0]  frame_index;
      logic [SMP_W-1:0]  left;
      logic [SMP_W-1:0]  right;
   } item_type;

endpackage

// ===== rtl/doarm_ram.sv =====
// generic single write, single read ram with registered read data
module doarm_ram #(
   parameter int Width = 32,
   parameter int Depth = 144,
   parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/doarm_front.sv =====
// control registers, store clearing sweep, request decode and store access stage
module doarm_front #(
   parameter int BlockFrames = doarm_pkg::BLOCK_FRAMES,
   parameter int AddrW = (BlockFrames > 1) ? $clog2(BlockFrames) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [doarm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [doarm_pkg::CSR_W-1:0]       csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_from_handheld,
   input  logic [doarm_pkg::IDX_W-1:0]       req_frame_index,
   input  logic signed [doarm_pkg::SMP_W-1:0] req_left_in,
   input  logic signed [doarm_pkg::SMP_W-1:0] req_right_in,
   output logic                              tv_we,
   output logic                              hh_we,
   output logic [AddrW-1:0]                  wr_addr,
   output logic [doarm_pkg::ENTRY_W-1:0]     wr_data,
   output logic                              rd_en,
   output logic [AddrW-1:0]                  rd_addr,
   output logic                              clr_busy,
   output logic                              s1_valid,
   output doarm_pkg::item_type               s1_item,
   input  logic                              s1_ready
);

   localparam logic [doarm_pkg::IDX_W:0] IdxLimit = (doarm_pkg::IDX_W + 1)'(BlockFrames);
   localparam logic [AddrW-1:0]          LastAddr = AddrW'(BlockFrames - 1);

   logic                 enable_ff;
   logic [2:0]           audio_mode_ff;
   logic [1:0]           screen_mode_ff;
   logic                 clr_busy_ff;
   logic [AddrW-1:0]     clr_addr_ff;
   logic [AddrW-1:0]     clr_addr_in;
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   doarm_pkg::item_type  s1_item_ff;
   doarm_pkg::op_type    op;
   logic                 in_range;
   logic                 emit;
   logic                 store;
   logic                 accept;

   // operation decode
   always_comb begin
      op = doarm_pkg::OP_PASS;
      if (enable_ff) begin
         case (audio_mode_ff)
            doarm_pkg::MODE_SWAP: begin
               op = doarm_pkg::OP_SWAP;
            end
            doarm_pkg::MODE_SCREEN: begin
               case (screen_mode_ff)
                  doarm_pkg::SCR_SWAP:      op = doarm_pkg::OP_SWAP;
                  doarm_pkg::SCR_MIRROR_TV: op = doarm_pkg::OP_MIRROR_TV;
                  doarm_pkg::SCR_MIRROR_HH: op = doarm_pkg::OP_MIRROR_HH;
                  default:                  op = doarm_pkg::OP_PASS;
               endcase
            end
            doarm_pkg::MODE_COMBINE: begin
               op = doarm_pkg::OP_COMBINE;
            end
            doarm_pkg::MODE_SPLIT: begin
               op = doarm_pkg::OP_SPLIT;
            end
            default: begin
               op = doarm_pkg::OP_PASS;
            end
         endcase
      end
   end

   assign in_range  = ({1'b0, req_frame_index} < IdxLimit);
   assign emit      = !enable_ff || in_range;
   assign store     = emit && (op inside {doarm_pkg::OP_MIRROR_TV, doarm_pkg::OP_MIRROR_HH,
                                          doarm_pkg::OP_COMBINE, doarm_pkg::OP_SPLIT});
   assign req_ready = !clr_busy_ff && (!s1_valid_ff || s1_ready);
   assign accept    = req_valid && req_ready;

   // store write: clearing sweep or own-stream store
   assign tv_we   = clr_busy_ff || (accept && store && !req_from_handheld);
   assign hh_we   = clr_busy_ff || (accept && store && req_from_handheld);
   assign wr_addr = clr_busy_ff ? clr_addr_ff : req_frame_index[AddrW-1:0];
   assign wr_data = clr_busy_ff ? '0 : {req_right_in, req_left_in};
   assign rd_en   = accept;
   assign rd_addr = req_frame_index[AddrW-1:0];

   assign clr_addr_in = clr_addr_ff + AddrW'(1);
   assign s1_valid_in = accept || (s1_valid_ff && !s1_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         audio_mode_ff  <= doarm_pkg::MODE_PASS;
         screen_mode_ff <= doarm_pkg::SCR_NONE;
         clr_busy_ff    <= 1'b1;
         clr_addr_ff    <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               doarm_pkg::CSR_ENABLE:      enable_ff      <= csr_wdata[0];
               doarm_pkg::CSR_AUDIO_MODE:  audio_mode_ff  <= csr_wdata;
               doarm_pkg::CSR_SCREEN_MODE: screen_mode_ff <= csr_wdata[1:0];
               default: ;
            endcase
         end
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_in;
            if (clr_addr_ff == LastAddr) begin
               clr_busy_ff <= 1'b0;
            end
         end
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.from_handheld <= req_from_handheld;
         s1_item_ff.emit          <= emit;
         s1_item_ff.op            <= op;
         s1_item_ff.frame_index   <= req_frame_index;
         s1_item_ff.left          <= req_left_in;
         s1_item_ff.right         <= req_right_in;
      end
   end

   assign clr_busy = clr_busy_ff;
   assign s1_valid = s1_valid_ff;
   assign s1_item  = s1_item_ff;

endmodule

// ===== rtl/doarm_mix.sv =====
// operand select stage, averaging adder stage and response register
module doarm_mix (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               s1_valid,
   input  doarm_pkg::item_type                s1_item,
   output logic                               s1_ready,
   input  logic [doarm_pkg::ENTRY_W-1:0]      tv_rd_data,
   input  logic [doarm_pkg::ENTRY_W-1:0]      hh_rd_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_to_handheld,
   output logic [doarm_pkg::IDX_W-1:0]        rsp_out_index,
   output logic signed [doarm_pkg::SMP_W-1:0] rsp_left_out,
   output logic signed [doarm_pkg::SMP_W-1:0] rsp_right_out
);

   localparam int SW = doarm_pkg::SMP_W;

   logic [doarm_pkg::ENTRY_W-1:0] own;
   logic [doarm_pkg::ENTRY_W-1:0] tv;
   logic [doarm_pkg::ENTRY_W-1:0] hh;
   logic [SW-1:0]                 la_in;
   logic [SW-1:0]                 lb_in;
   logic [SW-1:0]                 ra_in;
   logic [SW-1:0]                 rb_in;
   logic                          dest_in;

   logic                          s2_valid_ff;
   logic                          s2_valid_in;
   logic                          s2_dest_ff;
   logic [doarm_pkg::IDX_W-1:0]   s2_idx_ff;
   logic [SW-1:0]                 s2_la_ff;
   logic [SW-1:0]                 s2_lb_ff;
   logic [SW-1:0]                 s2_ra_ff;
   logic [SW-1:0]                 s2_rb_ff;
   logic                          s2_ready;
   logic                          s2_load;

   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic                          out_dest_ff;
   logic [doarm_pkg::IDX_W-1:0]   out_idx_ff;
   logic [SW-1:0]                 out_left_ff;
   logic [SW-1:0]                 out_right_ff;
   logic                          out_ready;
   logic [SW:0]                   sum_l;
   logic [SW:0]                   sum_r;

   // own entry is the one just written, the other comes from its store
   assign own = {s1_item.right, s1_item.left};
   assign tv  = s1_item.from_handheld ? tv_rd_data : own;
   assign hh  = s1_item.from_handheld ? own : hh_rd_data;

   // pass-through ops add a sample to itself so the halving returns it
   always_comb begin
      dest_in = s1_item.from_handheld;
      la_in   = s1_item.left;
      lb_in   = s1_item.left;
      ra_in   = s1_item.right;
      rb_in   = s1_item.right;
      case (s1_item.op)
         doarm_pkg::OP_SWAP: begin
            dest_in = !s1_item.from_handheld;
         end
         doarm_pkg::OP_MIRROR_TV: begin
            la_in = tv[SW-1:0];
            lb_in = tv[SW-1:0];
            ra_in = tv[2*SW-1:SW];
            rb_in = tv[2*SW-1:SW];
         end
         doarm_pkg::OP_MIRROR_HH: begin
            la_in = hh[SW-1:0];
            lb_in = hh[SW-1:0];
            ra_in = hh[2*SW-1:SW];
            rb_in = hh[2*SW-1:SW];
         end
         doarm_pkg::OP_COMBINE: begin
            la_in = tv[SW-1:0];
            lb_in = hh[SW-1:0];
            ra_in = tv[2*SW-1:SW];
            rb_in = hh[2*SW-1:SW];
         end
         doarm_pkg::OP_SPLIT: begin
            la_in = hh[SW-1:0];
            lb_in = hh[2*SW-1:SW];
            ra_in = tv[SW-1:0];
            rb_in = tv[2*SW-1:SW];
         end
         default: ;
      endcase
   end

   assign out_ready    = !out_valid_ff || rsp_ready;
   assign s2_ready     = !s2_valid_ff || out_ready;
   assign s1_ready     = s2_ready;
   assign s2_load      = s1_valid && s2_ready;
   assign s2_valid_in  = (s1_valid && s1_item.emit) || (s2_valid_ff && !out_ready);
   assign out_valid_in = s2_valid_ff || (out_valid_ff && !rsp_ready);

   // floor of the half sum; the result always fits 16 bits
   assign sum_l = {s2_la_ff[SW-1], s2_la_ff} + {s2_lb_ff[SW-1], s2_lb_ff};
   assign sum_r = {s2_ra_ff[SW-1], s2_ra_ff} + {s2_rb_ff[SW-1], s2_rb_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_dest_ff <= dest_in;
         s2_idx_ff  <= s1_item.frame_index;
         s2_la_ff   <= la_in;
         s2_lb_ff   <= lb_in;
         s2_ra_ff   <= ra_in;
         s2_rb_ff   <= rb_in;
      end
      if (s2_valid_ff && out_ready) begin
         out_dest_ff  <= s2_dest_ff;
         out_idx_ff   <= s2_idx_ff;
         out_left_ff  <= sum_l[SW:1];
         out_right_ff <= sum_r[SW:1];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_to_handheld = out_dest_ff;
   assign rsp_out_index   = out_idx_ff;
   assign rsp_left_out    = out_left_ff;
   assign rsp_right_out   = out_right_ff;

   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !out_ready |=> s2_valid_ff && $stable(s2_la_ff) && $stable(s2_idx_ff))
      else $error("stage two item lost or changed during stall");

endmodule

// ===== rtl/dual_output_audio_router_mixer.sv =====
// top level of the dual output audio router mixer
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_ready   from_handheld, frame_index, left_in, right_in
//   rsp_      out        rsp_valid / rsp_ready   to_handheld, out_index, left_out, right_out
//   csr_      in         csr_we                  csr_index, csr_wdata
//
// one request per cycle while req_ready; each reads both stores, writes at most its own store
// three register stages: the first stage, the second stage and the response register
// after reset both stores are cleared by a sweep over all BlockFrames entries, req_ready low
// a stall at rsp_ready backs up stage by stage, nothing is dropped or repeated
// dropped requests leave the pipeline at the first stage and never enter the second
module dual_output_audio_router_mixer #(
   parameter int BlockFrames = doarm_pkg::BLOCK_FRAMES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [doarm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [doarm_pkg::CSR_W-1:0]        csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_from_handheld,
   input  logic [doarm_pkg::IDX_W-1:0]        req_frame_index,
   input  logic signed [doarm_pkg::SMP_W-1:0] req_left_in,
   input  logic signed [doarm_pkg::SMP_W-1:0] req_right_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_to_handheld,
   output logic [doarm_pkg::IDX_W-1:0]        rsp_out_index,
   output logic signed [doarm_pkg::SMP_W-1:0] rsp_left_out,
   output logic signed [doarm_pkg::SMP_W-1:0] rsp_right_out
);

   localparam int AddrW = (BlockFrames > 1) ? $clog2(BlockFrames) : 1;

   logic                          tv_we;
   logic                          hh_we;
   logic [AddrW-1:0]              wr_addr;
   logic [doarm_pkg::ENTRY_W-1:0] wr_data;
   logic                          rd_en;
   logic [AddrW-1:0]              rd_addr;
   logic [doarm_pkg::ENTRY_W-1:0] tv_rd_data;
   logic [doarm_pkg::ENTRY_W-1:0] hh_rd_data;
   logic                          clr_busy;
   logic                          s1_valid;
   doarm_pkg::item_type           s1_item;
   logic                          s1_ready;

   doarm_front #(
      .BlockFrames (BlockFrames),
      .AddrW       (AddrW)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_from_handheld (req_from_handheld),
      .req_frame_index   (req_frame_index),
      .req_left_in       (req_left_in),
      .req_right_in      (req_right_in),
      .tv_we             (tv_we),
      .hh_we             (hh_we),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .clr_busy          (clr_busy),
      .s1_valid          (s1_valid),
      .s1_item           (s1_item),
      .s1_ready          (s1_ready)
   );

   doarm_ram #(
      .Width (doarm_pkg::ENTRY_W),
      .Depth (BlockFrames),
      .AddrW (AddrW)
   ) u_tv_store (
      .clock   (clock),
      .wr_en   (tv_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (tv_rd_data)
   );

   doarm_ram #(
      .Width (doarm_pkg::ENTRY_W),
      .Depth (BlockFrames),
      .AddrW (AddrW)
   ) u_hh_store (
      .clock   (clock),
      .wr_en   (hh_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (hh_rd_data)
   );

   doarm_mix u_mix (
      .clock           (clock),
      .reset           (reset),
      .s1_valid        (s1_valid),
      .s1_item         (s1_item),
      .s1_ready        (s1_ready),
      .tv_rd_data      (tv_rd_data),
      .hh_rd_data      (hh_rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_to_handheld (rsp_to_handheld),
      .rsp_out_index   (rsp_out_index),
      .rsp_left_out    (rsp_left_out),
      .rsp_right_out   (rsp_right_out)
   );

   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !req_ready)
      else $error("request taken during store clearing");

   a_one_store_write: assert property (@(posedge clock) disable iff (reset)
      tv_we && hh_we |-> clr_busy)
      else $error("both stores written by one request");

   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> clr_busy)
      else $error("store clearing not started after reset");

   a_read_on_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid)
      else $error("taken request missing from first stage");

endmodule
